/* rtl/scs_pkg.sv */
package scs_pkg;

	// input item kinds
	localparam logic [1:0] KIND_FIRST  = 2'd0;
	localparam logic [1:0] KIND_SECOND = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;

	// one result beat
	typedef struct packed {
		logic [7:0] sym;
		logic       last;
		logic       empty;
		logic       ovf;
	} scs_beat_t;

	// decision flags from the cell unit
	typedef struct packed {
		logic eq;
		logic up_gt;
	} scs_dec_t;

endpackage

/* rtl/scs_cell.sv */
module scs_cell import scs_pkg::*; #(
	parameter int CW = 6
) (
	input  logic [7:0]    sym_a,
	input  logic [7:0]    sym_b,
	input  logic [CW-1:0] up,
	input  logic [CW-1:0] left,
	input  logic [CW-1:0] diag,
	output logic [CW-1:0] val,
	output scs_dec_t      dec
);

	// symbol compare and neighbor max, shared by table fill and traceback
	always_comb begin
		dec.eq    = (sym_a == sym_b);
		dec.up_gt = (up > left);
		if (dec.eq) begin
			val = diag + CW'(1);
		end else if (dec.up_gt) begin
			val = up;
		end else begin
			val = left;
		end
	end

endmodule

/* rtl/scs_obuf.sv */
module scs_obuf import scs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  scs_beat_t beat,
	output logic      free,
	output logic      valid,
	input  logic      ready,
	output scs_beat_t beat_q
);

	logic valid_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;

	// output holding register, refilled in the cycle the old beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= beat;
		end
	end

endmodule

/* rtl/shortest_common_supersequence.sv */
// Shortest common supersequence of two byte strings of up to MAX_LEN symbols
// each. Kind 0 and 1 beats append a symbol to the first or second string;
// a symbol past MAX_LEN is dropped and the sticky overflow flag (cleared
// only by reset) is raised. A kind 2 beat builds the LCS table with one
// compare/max unit and a table memory with one read and one write port,
// walks it back, and emits the supersequence in forward order, last set on
// the final beat; two empty strings give one beat with empty_res set. Kind 3
// is ignored. The fill does one table read per cell, traceback steps pass
// TB1 to TB3, leftover symbols TL1 and TL2, and emitted bytes EM1 and EM2,
// held by any output stall; in_ready is low for the whole run. The string
// lengths are zero again once the run is emitted.
module shortest_common_supersequence import scs_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_symbol,
	output logic       last,
	output logic       empty_res,
	output logic       overflow
);

	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int TD  = MAX_LEN * MAX_LEN;
	localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
	localparam int BD  = 2 * MAX_LEN;
	localparam int BAW = $clog2(BD);
	localparam int NW  = $clog2(BD + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EMPTY = 4'd1;
	localparam logic [3:0] S_ROW   = 4'd2;
	localparam logic [3:0] S_FRD   = 4'd3;
	localparam logic [3:0] S_FWR   = 4'd4;
	localparam logic [3:0] S_TB1   = 4'd5;
	localparam logic [3:0] S_TB2   = 4'd6;
	localparam logic [3:0] S_TB3   = 4'd7;
	localparam logic [3:0] S_TL1   = 4'd8;
	localparam logic [3:0] S_TL2   = 4'd9;
	localparam logic [3:0] S_EM1   = 4'd10;
	localparam logic [3:0] S_EM2   = 4'd11;

	logic [3:0]    state_q;
	logic [LW-1:0] la_q, lb_q, r_q, c_q;
	logic [NW-1:0] cnt_q;
	logic          drop_q;

	logic [7:0]    a_q, b_q;
	logic [LW-1:0] up_q, left_q, diag_q;

	logic [7:0]    fa_mem [MAX_LEN];
	logic [7:0]    fb_mem [MAX_LEN];
	logic [LW-1:0] tbl_mem [TD];
	logic [7:0]    tb_mem [BD];
	logic [7:0]    fa_rd, fb_rd, tb_rd;
	logic [LW-1:0] tbl_rd;

	logic          in_accept;
	logic          fa_we, fb_we, tbl_we, tb_we;
	logic [LW-1:0] r_m1, c_m1;
	logic [AW-1:0] fa_ra, fb_ra;
	logic [TAW-1:0] tbl_ra, tbl_wa;
	logic [NW-1:0] cnt_m1;
	logic [BAW-1:0] tb_ra;
	logic [7:0]    tb_wd;

	logic [7:0]    u_b;
	logic [LW-1:0] u_up, u_left, cell_val;
	scs_dec_t      dec;

	logic          ob_load, ob_free;
	scs_beat_t     ob_beat, ob_q;

	function automatic logic [TAW-1:0] tidx(input logic [LW-1:0] row,
		input logic [LW-1:0] col);
		logic [LW-1:0] rm1;
		logic [LW-1:0] cm1;
		rm1 = row - LW'(1);
		cm1 = col - LW'(1);
		return TAW'(rm1) * TAW'(MAX_LEN) + TAW'(cm1);
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;

	// string stores, read at the current row and column
	assign r_m1  = r_q - LW'(1);
	assign c_m1  = c_q - LW'(1);
	assign fa_ra = r_m1[AW-1:0];
	assign fb_ra = c_m1[AW-1:0];
	assign fa_we = in_accept && (kind == KIND_FIRST) && (la_q < LEN_MAX);
	assign fb_we = in_accept && (kind == KIND_SECOND) && (lb_q < LEN_MAX);

	always_ff @(posedge clk) begin
		if (fa_we) begin
			fa_mem[la_q[AW-1:0]] <= symbol;
		end
		fa_rd <= fa_mem[fa_ra];
	end

	always_ff @(posedge clk) begin
		if (fb_we) begin
			fb_mem[lb_q[AW-1:0]] <= symbol;
		end
		fb_rd <= fb_mem[fb_ra];
	end

	// lcs table, interior cells only; row and column zero read as zero
	assign tbl_ra = (state_q == S_TB2) ? tidx(r_q, c_m1) : tidx(r_m1, c_q);
	assign tbl_wa = tidx(r_q, c_q);
	assign tbl_we = (state_q == S_FWR);

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= cell_val;
		end
		tbl_rd <= tbl_mem[tbl_ra];
	end

	// shared cell unit operands
	always_comb begin
		if (state_q == S_FWR) begin
			u_b    = fb_rd;
			u_up   = (r_q == LW'(1)) ? '0 : tbl_rd;
			u_left = left_q;
		end else begin
			u_b    = b_q;
			u_up   = up_q;
			u_left = (c_q == LW'(1)) ? '0 : tbl_rd;
		end
	end

	scs_cell #(.CW(LW)) u_cell (
		.sym_a (a_q),
		.sym_b (u_b),
		.up    (u_up),
		.left  (u_left),
		.diag  (diag_q),
		.val   (cell_val),
		.dec   (dec)
	);

	// reverse-order trace buffer, written at cnt and drained from cnt-1
	assign cnt_m1 = cnt_q - NW'(1);
	assign tb_ra  = cnt_m1[BAW-1:0];
	assign tb_we  = (state_q == S_TB3) || (state_q == S_TL2);

	always_comb begin
		if (state_q == S_TL2) begin
			tb_wd = (r_q != '0) ? fa_rd : fb_rd;
		end else begin
			tb_wd = (dec.eq || dec.up_gt) ? a_q : b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tb_we) begin
			tb_mem[cnt_q[BAW-1:0]] <= tb_wd;
		end
		tb_rd <= tb_mem[tb_ra];
	end

	// operand registers for the cell unit
	always_ff @(posedge clk) begin
		case (state_q)
			S_ROW: begin
				left_q <= '0;
				diag_q <= '0;
			end
			S_FRD: begin
				if (c_q == LW'(1)) begin
					a_q <= fa_rd;
				end
			end
			S_FWR: begin
				left_q <= cell_val;
				diag_q <= u_up;
			end
			S_TB2: begin
				a_q  <= fa_rd;
				b_q  <= fb_rd;
				up_q <= (r_q == LW'(1)) ? '0 : tbl_rd;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			la_q    <= '0;
			lb_q    <= '0;
			r_q     <= '0;
			c_q     <= '0;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (kind)
							KIND_FIRST: begin
								if (la_q < LEN_MAX) begin
									la_q <= la_q + LW'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							KIND_SECOND: begin
								if (lb_q < LEN_MAX) begin
									lb_q <= lb_q + LW'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							KIND_RUN: begin
								cnt_q <= '0;
								if (la_q == '0 && lb_q == '0) begin
									state_q <= S_EMPTY;
								end else if (la_q == '0 || lb_q == '0) begin
									r_q     <= la_q;
									c_q     <= lb_q;
									state_q <= S_TL1;
								end else begin
									r_q     <= LW'(1);
									state_q <= S_ROW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EMPTY: begin
					if (ob_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ROW: begin
					c_q     <= LW'(1);
					state_q <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					if (c_q == lb_q) begin
						if (r_q == la_q) begin
							state_q <= S_TB1;
						end else begin
							r_q     <= r_q + LW'(1);
							state_q <= S_ROW;
						end
					end else begin
						c_q     <= c_q + LW'(1);
						state_q <= S_FRD;
					end
				end
				S_TB1: begin
					if (r_q == '0 || c_q == '0) begin
						state_q <= S_TL1;
					end else begin
						state_q <= S_TB2;
					end
				end
				S_TB2: begin
					state_q <= S_TB3;
				end
				S_TB3: begin
					cnt_q <= cnt_q + NW'(1);
					if (dec.eq) begin
						r_q <= r_m1;
						c_q <= c_m1;
					end else if (dec.up_gt) begin
						r_q <= r_m1;
					end else begin
						c_q <= c_m1;
					end
					state_q <= S_TB1;
				end
				S_TL1: begin
					if (r_q != '0 || c_q != '0) begin
						state_q <= S_TL2;
					end else begin
						state_q <= S_EM1;
					end
				end
				S_TL2: begin
					cnt_q <= cnt_q + NW'(1);
					if (r_q != '0) begin
						r_q <= r_m1;
					end else begin
						c_q <= c_m1;
					end
					state_q <= S_TL1;
				end
				S_EM1: begin
					state_q <= S_EM2;
				end
				S_EM2: begin
					if (ob_free) begin
						cnt_q <= cnt_m1;
						if (cnt_q == NW'(1)) begin
							la_q    <= '0;
							lb_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EM1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat into the output register
	assign ob_load = ((state_q == S_EMPTY) || (state_q == S_EM2)) && ob_free;

	always_comb begin
		ob_beat.ovf = drop_q;
		if (state_q == S_EMPTY) begin
			ob_beat.sym   = 8'd0;
			ob_beat.last  = 1'b1;
			ob_beat.empty = 1'b1;
		end else begin
			ob_beat.sym   = tb_rd;
			ob_beat.last  = (cnt_q == NW'(1));
			ob_beat.empty = 1'b0;
		end
	end

	scs_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ob_load),
		.beat   (ob_beat),
		.free   (ob_free),
		.valid  (out_valid),
		.ready  (out_ready),
		.beat_q (ob_q)
	);

	assign out_symbol = ob_q.sym;
	assign last       = ob_q.last;
	assign empty_res  = ob_q.empty;
	assign overflow   = ob_q.ovf;

	// an empty-run beat is always the last one and carries a zero byte
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_res) |-> (last && out_symbol == 8'd0))
		else $error("empty result beat malformed");

	// string lengths stay within capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(la_q <= LEN_MAX) && (lb_q <= LEN_MAX))
		else $error("string length beyond capacity");

	// an lcs cell never exceeds its row or column index
	a_cell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FWR) |-> ((cell_val <= r_q) && (cell_val <= c_q)))
		else $error("lcs cell value out of bound");

	// the output register is only refilled when its beat has left
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(out_symbol) && $stable(last)))
		else $error("pending result beat overwritten");

endmodule

/* test/shortest_common_supersequence_tb.sv */
module shortest_common_supersequence_tb import scs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 32;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 100;

	// kind code that the block ignores
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] sym;
	} scs_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = KIND_FIRST;
	logic [7:0] symbol = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_symbol;
	logic       last;
	logic       empty_res;
	logic       overflow;

	// stimulus and scoreboard
	scs_item_t  pending_items[$];
	scs_item_t  next_item;
	scs_beat_t  scs_due[$];
	scs_beat_t  want;
	int         items_queued = 0;
	int         items_total = 0;
	int         items_accepted = 0;
	int         send_gap = 0;
	int         hold_cnt = 0;
	int         idle_cycles = 0;
	int         mismatches = 0;
	int         runs_seen = 0;
	int         bytes_checked = 0;
	int         loads_seen = 0;

	// predictor state
	logic [7:0] first_str [MAX_LEN];
	logic [7:0] second_str [MAX_LEN];
	logic [5:0] first_len = '0;
	logic [5:0] second_len = '0;
	logic       drop_seen = 1'b0;
	logic [5:0] lcs_len [0:MAX_LEN][0:MAX_LEN];

	shortest_common_supersequence #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_symbol(out_symbol),
		.last      (last),
		.empty_res (empty_res),
		.overflow  (overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// loads, runs the lcs fill and traceback, and queues the supersequence bytes
	task automatic predict_scs(input logic [1:0] op, input logic [7:0] sym);
		logic [7:0] fwd [$];
		scs_beat_t  b;
		int         r;
		int         c;
		int         i;
		case (op)
			KIND_FIRST: begin
				loads_seen++;
				if (first_len < MAX_LEN) begin
					first_str[first_len[4:0]] = sym;
					first_len++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			KIND_SECOND: begin
				loads_seen++;
				if (second_len < MAX_LEN) begin
					second_str[second_len[4:0]] = sym;
					second_len++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			KIND_RUN: begin
				runs_seen++;
				if (first_len == 0 && second_len == 0) begin
					b.sym = 8'h00;
					b.last = 1'b1;
					b.empty = 1'b1;
					b.ovf = drop_seen;
					scs_due.push_back(b);
				end else begin
					// table fill
					for (r = 0; r <= first_len; r++)
						lcs_len[r][0] = '0;
					for (c = 0; c <= second_len; c++)
						lcs_len[0][c] = '0;
					for (r = 1; r <= first_len; r++) begin
						for (c = 1; c <= second_len; c++) begin
							if (first_str[r-1] == second_str[c-1])
								lcs_len[r][c] = lcs_len[r-1][c-1] + 6'd1;
							else if (lcs_len[r-1][c] > lcs_len[r][c-1])
								lcs_len[r][c] = lcs_len[r-1][c];
							else
								lcs_len[r][c] = lcs_len[r][c-1];
						end
					end
					// walk back from the far corner, building forward order
					r = first_len;
					c = second_len;
					while (r > 0 && c > 0) begin
						if (first_str[r-1] == second_str[c-1]) begin
							fwd.push_front(first_str[r-1]);
							r--;
							c--;
						end else if (lcs_len[r-1][c] > lcs_len[r][c-1]) begin
							fwd.push_front(first_str[r-1]);
							r--;
						end else begin
							fwd.push_front(second_str[c-1]);
							c--;
						end
					end
					while (r > 0) begin
						fwd.push_front(first_str[r-1]);
						r--;
					end
					while (c > 0) begin
						fwd.push_front(second_str[c-1]);
						c--;
					end
					for (i = 0; i < fwd.size(); i++) begin
						b.sym = fwd[i];
						b.last = (i == fwd.size() - 1);
						b.empty = 1'b0;
						b.ovf = drop_seen;
						scs_due.push_back(b);
					end
					first_len = '0;
					second_len = '0;
				end
			end
			default: begin
				// ignored kind
			end
		endcase
	endtask

	task automatic queue_item(input logic [1:0] op, input logic [7:0] sym);
		scs_item_t it;
		it.op = op;
		it.sym = sym;
		pending_items.push_back(it);
		items_total++;
		if (op != KIND_UNUSED)
			items_queued++;
	endtask

	// two strings loaded in random interleave, then a run; span 255 means any byte
	task automatic queue_strings(input int n, input int m, input int span);
		int a;
		int b;
		int base;
		logic [7:0] sym;
		a = 0;
		b = 0;
		base = $urandom_range(0, 255 - span);
		while (a < n || b < m) begin
			if ($urandom_range(0, 99) < 4)
				queue_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
			sym = 8'(base + $urandom_range(0, span));
			if (b >= m || (a < n && $urandom_range(0, 1) == 0)) begin
				queue_item(KIND_FIRST, sym);
				a++;
			end else begin
				queue_item(KIND_SECOND, sym);
				b++;
			end
		end
		queue_item(KIND_RUN, 8'($urandom_range(0, 255)));
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_FIRST;
			symbol <= 8'h00;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				kind <= next_item.op;
				symbol <= next_item.sym;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 25) begin
			hold_cnt <= pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on input beats, compare output beats
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_scs(kind, symbol);
			items_accepted++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (scs_due.size() == 0) begin
				$error("unexpected beat: out_symbol %02h last %0d", out_symbol, last);
				mismatches++;
			end else begin
				want = scs_due.pop_front();
				bytes_checked++;
				if (out_symbol !== want.sym) begin
					$error("out_symbol: expected %02h, got %02h", want.sym, out_symbol);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
				if (empty_res !== want.empty) begin
					$error("empty_res: expected %0d, got %0d", want.empty, empty_res);
					mismatches++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow: expected %0d, got %0d", want.ovf, overflow);
					mismatches++;
				end
			end
		end
	end

	// cycles without any beat on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int r;
		int lo;
		int hi;

		// directed: both empty, ignored kind, byte extremes, one-sided, equal, tie
		queue_item(KIND_RUN, 8'h00);
		queue_item(KIND_UNUSED, 8'hFF);
		queue_item(KIND_FIRST, 8'h00);
		queue_item(KIND_SECOND, 8'hFF);
		queue_item(KIND_RUN, 8'hFF);
		queue_item(KIND_FIRST, 8'hA5);
		queue_item(KIND_FIRST, 8'h5A);
		queue_item(KIND_RUN, 8'h00);
		queue_item(KIND_SECOND, 8'h80);
		queue_item(KIND_UNUSED, 8'h00);
		queue_item(KIND_SECOND, 8'h01);
		queue_item(KIND_RUN, 8'h00);
		queue_item(KIND_FIRST, 8'h61);
		queue_item(KIND_SECOND, 8'h61);
		queue_item(KIND_FIRST, 8'h62);
		queue_item(KIND_SECOND, 8'h62);
		queue_item(KIND_FIRST, 8'h63);
		queue_item(KIND_SECOND, 8'h63);
		queue_item(KIND_RUN, 8'h00);
		queue_item(KIND_FIRST, 8'h61);
		queue_item(KIND_FIRST, 8'h62);
		queue_item(KIND_SECOND, 8'h62);
		queue_item(KIND_SECOND, 8'h61);
		queue_item(KIND_RUN, 8'h00);

		// random runs, mostly short strings over a small alphabet
		while (items_queued < RANDOM_ITEMS + 24) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				lo = 0;
				hi = 8;
			end else if (r < 95) begin
				lo = 9;
				hi = 20;
			end else begin
				lo = 21;
				hi = MAX_LEN;
			end
			queue_strings($urandom_range(lo, hi), $urandom_range(lo, hi),
				($urandom_range(0, 99) < 70) ? 3 : 255);
		end

		// string full: drops set the sticky flag, seen on later runs too
		queue_strings(MAX_LEN + 2, 2, 3);
		queue_strings(2, 3, 255);
		queue_item(KIND_RUN, 8'h00);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted != items_total)
			@(posedge clk);
		while (scs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d input beats: %0d loads, %0d supersequence runs",
			items_accepted, loads_seen, runs_seen);
		$display("%0d output bytes checked, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
